// ===== hw/rtl/aesbe_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aesbe_pkg
// Shared types, constants and byte functions of the block cipher datapath.
// ----------------------------------------------------------------------------
package aesbe_pkg;

   localparam int NUM_RKEYS = 13;
   localparam int REG_ADDR_W = 5;

   localparam logic [3:0] NR_128 = 4'd10;
   localparam logic [3:0] NR_192 = 4'd12;

   localparam logic [7:0] GF_REDUCE = 8'h1b;
   localparam logic [7:0] GF_TOP = 8'h80;
   localparam logic [7:0] RCON_FIRST = 8'h01;

   // register indexes (paddr[4:3])
   localparam logic [1:0] REG_MODE = 2'd0;
   localparam logic [1:0] REG_KEY_HIGH = 2'd1;
   localparam logic [1:0] REG_KEY_MID = 2'd2;
   localparam logic [1:0] REG_KEY_LOW = 2'd3;

   typedef logic [NUM_RKEYS-1:0][127:0] rkey_array_type;

   typedef struct packed {
      logic add_only;
      logic last;
      logic bypass;
   } stage_ctl_type;

   typedef enum logic [0:0] {
      KX_IDLE,
      KX_RUN
   } kx_state_type;

   localparam logic [2047:0] SBOX_BITS = {
      256'h637c777bf26b6fc53001672bfed7ab76ca82c97dfa5947f0add4a2af9ca472c0,
      256'hb7fd9326363ff7cc34a5e5f171d8311504c723c31896059a071280e2eb27b275,
      256'h09832c1a1b6e5aa0523bd6b329e32f8453d100ed20fcb15b6acbbe394a4c58cf,
      256'hd0efaafb434d338545f9027f503c9fa851a3408f929d38f5bcb6da2110fff3d2,
      256'hcd0c13ec5f974417c4a77e3d645d197360814fdc222a908846eeb814de5e0bdb,
      256'he0323a0a4906245cc2d3ac629195e479e7c8376d8dd54ea96c56f4ea657aae08,
      256'hba78252e1ca6b4c6e8dd741f4bbd8b8a703eb5664803f60e613557b986c11d9e,
      256'he1f8981169d98e949b1e87e9ce5528df8ca1890dbfe6426841992d0fb054bb16
   };

   function automatic logic [7:0] sbox(input logic [7:0] b);
      sbox = SBOX_BITS[2047 - 8 * int'(b) -: 8];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] b);
      logic [7:0] d;
      d = {b[6:0], 1'b0};
      if ((b & GF_TOP) != 8'h00) begin
         d = d ^ GF_REDUCE;
      end
      xtime = d;
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

   // byte i of the state sits at bits 127-8i downto 120-8i
   function automatic logic [127:0] sub_shift(input logic [127:0] s);
      logic [127:0] t;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            t[127 - 8 * (r + 4 * c) -: 8] =
               sbox(s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]);
         end
      end
      sub_shift = t;
   endfunction

   function automatic logic [127:0] mix_cols(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
      for (int c = 0; c < 4; c++) begin
         a0 = s[127 - 32 * c -: 8];
         a1 = s[119 - 32 * c -: 8];
         a2 = s[111 - 32 * c -: 8];
         a3 = s[103 - 32 * c -: 8];
         d0 = xtime(a0);
         d1 = xtime(a1);
         d2 = xtime(a2);
         d3 = xtime(a3);
         t[127 - 32 * c -: 8] = d0 ^ d1 ^ a1 ^ a2 ^ a3;
         t[119 - 32 * c -: 8] = a0 ^ d1 ^ d2 ^ a2 ^ a3;
         t[111 - 32 * c -: 8] = a0 ^ a1 ^ d2 ^ d3 ^ a3;
         t[103 - 32 * c -: 8] = d0 ^ a0 ^ a1 ^ a2 ^ d3;
      end
      mix_cols = t;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/aesbe_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aesbe_req_if
// Plaintext channel: valid/ready with one 128-bit block per transfer.
// ----------------------------------------------------------------------------
interface aesbe_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] plain_high;
   logic [63:0] plain_low;

   modport source (output valid, output plain_high, output plain_low, input ready);
   modport sink (input valid, input plain_high, input plain_low, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/aesbe_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aesbe_rsp_if
// Ciphertext channel: valid/ready with one 128-bit block per transfer.
// ----------------------------------------------------------------------------
interface aesbe_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] cipher_high;
   logic [63:0] cipher_low;

   modport source (output valid, output cipher_high, output cipher_low, input ready);
   modport sink (input valid, input cipher_high, input cipher_low, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/aesbe_key_expand.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aesbe_key_expand
// Key schedule sequencer: one 32-bit schedule word per cycle into the
// round key registers.
// ----------------------------------------------------------------------------
module aesbe_key_expand (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic                     mode,
   input  wire logic [63:0]              key_high,
   input  wire logic [63:0]              key_mid,
   input  wire logic [63:0]              key_low,
   output logic                          busy,
   output aesbe_pkg::rkey_array_type     round_keys
);

   aesbe_pkg::kx_state_type state_ff, state_in;
   logic                    pend_ff, pend_in;
   logic [5:0]              idx_ff, idx_in;
   logic [2:0]              pos_ff, pos_in;
   logic [7:0]              rcon_ff, rcon_in;
   logic [5:0][31:0]        win_ff;
   aesbe_pkg::rkey_array_type rk_ff;

   logic [2:0]  nk;
   logic [5:0]  last_idx;
   logic        load;
   logic [31:0] tmp;
   logic [31:0] prev;
   logic [31:0] word;

   assign nk = mode ? 3'd6 : 3'd4;
   assign last_idx = mode ? 6'd51 : 6'd43;

   // next schedule word
   always_comb begin
      tmp = win_ff[5];
      if (pos_ff == 3'd0) begin
         tmp = aesbe_pkg::sub_word({tmp[23:0], tmp[31:24]}) ^ {rcon_ff, 24'h000000};
      end
      prev = mode ? win_ff[0] : win_ff[2];
      word = prev ^ tmp;
   end

   // sequencer control
   always_comb begin
      state_in = state_ff;
      pend_in = pend_ff | start;
      idx_in = idx_ff;
      pos_in = pos_ff;
      rcon_in = rcon_ff;
      load = 1'b0;
      case (state_ff)
         aesbe_pkg::KX_IDLE: begin
            if (pend_ff) begin
               load = 1'b1;
               pend_in = start;
               state_in = aesbe_pkg::KX_RUN;
               idx_in = {3'd0, nk};
               pos_in = 3'd0;
               rcon_in = aesbe_pkg::RCON_FIRST;
            end
         end
         aesbe_pkg::KX_RUN: begin
            idx_in = idx_ff + 6'd1;
            pos_in = (pos_ff == nk - 3'd1) ? 3'd0 : pos_ff + 3'd1;
            if (pos_ff == 3'd0) begin
               rcon_in = aesbe_pkg::xtime(rcon_ff);
            end
            if (idx_ff == last_idx || start) begin
               state_in = aesbe_pkg::KX_IDLE;
            end
         end
         default: begin
            state_in = aesbe_pkg::KX_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aesbe_pkg::KX_IDLE;
         pend_ff <= 1'b1;
         idx_ff <= '0;
         pos_ff <= '0;
         rcon_ff <= aesbe_pkg::RCON_FIRST;
      end else begin
         state_ff <= state_in;
         pend_ff <= pend_in;
         idx_ff <= idx_in;
         pos_ff <= pos_in;
         rcon_ff <= rcon_in;
      end
   end

   // schedule window (newest word on top) and round key registers
   always_ff @(posedge clock) begin
      if (load) begin
         if (mode) begin
            win_ff <= {key_low[31:0], key_low[63:32], key_mid[31:0], key_mid[63:32],
                       key_high[31:0], key_high[63:32]};
         end else begin
            win_ff <= {key_mid[31:0], key_mid[63:32], key_high[31:0], key_high[63:32],
                       64'd0};
         end
         rk_ff[0] <= {key_high, key_mid};
         if (mode) begin
            rk_ff[1][127:64] <= key_low;
         end
      end else if (state_ff == aesbe_pkg::KX_RUN) begin
         win_ff <= {word, win_ff[5:1]};
         rk_ff[idx_ff[5:2]][127 - 32 * int'(idx_ff[1:0]) -: 32] <= word;
      end
   end

   assign busy = pend_ff || (state_ff == aesbe_pkg::KX_RUN);
   assign round_keys = rk_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/aesbe_round.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aesbe_round
// One pipeline stage: a full round, the last round, the initial key add or
// a pass-through, with its own valid bit and ready.
// ----------------------------------------------------------------------------
module aesbe_round (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire aesbe_pkg::stage_ctl_type ctl,
   input  wire logic [127:0]             round_key,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire logic [127:0]             in_state,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output logic [127:0]                  out_state
);

   logic         valid_ff;
   logic [127:0] state_ff, state_in;
   logic [127:0] sub_st;

   // round function
   always_comb begin
      sub_st = aesbe_pkg::sub_shift(in_state);
      if (!ctl.last) begin
         sub_st = aesbe_pkg::mix_cols(sub_st);
      end
      if (ctl.add_only) begin
         state_in = in_state ^ round_key;
      end else if (ctl.bypass) begin
         state_in = in_state;
      end else begin
         state_in = sub_st ^ round_key;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // stage data
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         state_ff <= state_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/aes_block_encrypt_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aes_block_encrypt_top
// AES-128/192 block encryption with a fully unrolled round pipeline.
// ----------------------------------------------------------------------------
// the pipeline is a key add stage and 12 round stages, each registered
// throughput: one block per cycle; each stage holds under rsp backpressure
// reset and every csr write restart the key schedule sequencer, one word a
// cycle; req.ready is low meanwhile. reset clears csr registers to zero and
// empties the pipeline
module aes_block_encrypt_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   aesbe_req_if.sink                             req_chan,
   aesbe_rsp_if.source                           rsp_chan,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [aesbe_pkg::REG_ADDR_W-1:0] csr_paddr,
   input  wire logic [63:0]                      csr_pwdata,
   output logic [63:0]                           csr_prdata,
   output logic                                  csr_pready
);

   localparam int NSTAGE = aesbe_pkg::NUM_RKEYS;

   logic        mode_ff;
   logic [63:0] key_high_ff, key_mid_ff, key_low_ff;
   logic        csr_wr;
   logic [1:0]  reg_idx;
   logic        kx_busy;
   logic [3:0]  nr;
   aesbe_pkg::rkey_array_type round_keys;

   logic [NSTAGE:0]        stg_valid;
   logic [NSTAGE:0]        stg_ready;
   logic [NSTAGE:0][127:0] stg_state;

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx = csr_paddr[4:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         key_high_ff <= '0;
         key_mid_ff <= '0;
         key_low_ff <= '0;
      end else if (csr_wr) begin
         case (reg_idx)
            aesbe_pkg::REG_MODE: mode_ff <= csr_pwdata[0];
            aesbe_pkg::REG_KEY_HIGH: key_high_ff <= csr_pwdata;
            aesbe_pkg::REG_KEY_MID: key_mid_ff <= csr_pwdata;
            aesbe_pkg::REG_KEY_LOW: key_low_ff <= csr_pwdata;
            default: key_low_ff <= key_low_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         aesbe_pkg::REG_MODE: csr_prdata = {63'd0, mode_ff};
         aesbe_pkg::REG_KEY_HIGH: csr_prdata = key_high_ff;
         aesbe_pkg::REG_KEY_MID: csr_prdata = key_mid_ff;
         aesbe_pkg::REG_KEY_LOW: csr_prdata = key_low_ff;
         default: csr_prdata = '0;
      endcase
   end

   // key schedule
   aesbe_key_expand u_key_expand (
      .clock      (clock),
      .reset      (reset),
      .start      (csr_wr),
      .mode       (mode_ff),
      .key_high   (key_high_ff),
      .key_mid    (key_mid_ff),
      .key_low    (key_low_ff),
      .busy       (kx_busy),
      .round_keys (round_keys)
   );

   assign nr = mode_ff ? aesbe_pkg::NR_192 : aesbe_pkg::NR_128;

   // pipeline input, held off while the schedule runs
   assign stg_valid[0] = req_chan.valid && !kx_busy;
   assign req_chan.ready = stg_ready[0] && !kx_busy;
   assign stg_state[0] = {req_chan.plain_high, req_chan.plain_low};

   // round stages
   for (genvar k = 0; k < NSTAGE; k++) begin : g_stage
      aesbe_pkg::stage_ctl_type ctl;
      assign ctl.add_only = (k == 0);
      assign ctl.last = (4'(k) == nr);
      assign ctl.bypass = (4'(k) > nr);

      aesbe_round u_round (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .round_key (round_keys[k]),
         .in_valid  (stg_valid[k]),
         .in_ready  (stg_ready[k]),
         .in_state  (stg_state[k]),
         .out_valid (stg_valid[k+1]),
         .out_ready (stg_ready[k+1]),
         .out_state (stg_state[k+1])
      );
   end

   // result channel
   assign rsp_chan.valid = stg_valid[NSTAGE];
   assign stg_ready[NSTAGE] = rsp_chan.ready;
   assign rsp_chan.cipher_high = stg_state[NSTAGE][127:64];
   assign rsp_chan.cipher_low = stg_state[NSTAGE][63:0];

`ifndef SYNTH
   // no block enters while round keys are being rebuilt
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |-> !kx_busy)
      else $error("block accepted during key expansion");

   // a register write stops intake on the next cycle
   a_wr_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_wr |=> !req_chan.ready)
      else $error("intake open right after register write");

   // a stalled result is never dropped
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (stg_valid[NSTAGE] && !rsp_chan.ready) |=> stg_valid[NSTAGE])
      else $error("stalled result lost");

   // a transfer on the input adds a valid to the first stage
   a_first_stage: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> stg_valid[1])
      else $error("accepted block missing from first stage");
`endif

endmodule
`default_nettype wire

// ===== verif/tb_aes_block_encrypt_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_aes_block_encrypt_top
// Drives plaintext blocks through the AES-128/192 block cipher under random
// idling on both channels and checks every ciphertext block against an
// in-bench cipher computed from the current key and key-size setting.
// ----------------------------------------------------------------------------
module tb_aes_block_encrypt_top;

   typedef struct packed {
      logic [63:0] high;
      logic [63:0] low;
   } block_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   aesbe_req_if req_chan ();
   aesbe_rsp_if rsp_chan ();

   logic                             csr_psel = 1'b0;
   logic                             csr_penable = 1'b0;
   logic                             csr_pwrite = 1'b0;
   logic [aesbe_pkg::REG_ADDR_W-1:0] csr_paddr = '0;
   logic [63:0]                      csr_pwdata = '0;
   logic [63:0]                      csr_prdata;
   logic                             csr_pready;

   aes_block_encrypt_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan.sink),
      .rsp_chan    (rsp_chan.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   // cipher key and mode copy, plus round keys expanded from them
   logic        mode_192;
   logic [63:0] key_high, key_mid, key_low;
   logic [31:0] sched [0:51];

   block_type plain_queue [$];
   block_type cipher_queue [$];
   int     mismatches = 0;
   int     idle_cycles = 0;
   int     req_gap = 0;
   int     rsp_gap = 0;
   int     rsp_hold = 0;

   localparam int WATCHDOG_LIMIT = 20000;

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p, aa;
      p = 8'h00; aa = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p = p ^ aa;
         aa = aa[7] ? ({aa[6:0], 1'b0} ^ 8'h1b) : {aa[6:0], 1'b0};
      end
      return p;
   endfunction

   function automatic logic [7:0] sb(input logic [7:0] b);
      logic [7:0] x, inv, r;
      // inverse by exponent 254 then affine map
      x = b; inv = 8'h01;
      for (int i = 0; i < 254; i++) inv = gmul(inv, x);
      r = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      return r;
   endfunction

   logic [7:0] sbox_lut [0:255];
   initial for (int i = 0; i < 256; i++) sbox_lut[i] = sb(i[7:0]);

   function automatic void expand_schedule();
      int nk, total;
      logic [31:0] t;
      logic [7:0] rc;
      nk = mode_192 ? 6 : 4;
      total = mode_192 ? 52 : 44;
      rc = 8'h01;
      sched[0] = key_high[63:32]; sched[1] = key_high[31:0];
      sched[2] = key_mid[63:32];  sched[3] = key_mid[31:0];
      sched[4] = key_low[63:32];  sched[5] = key_low[31:0];
      for (int i = nk; i < total; i++) begin
         t = sched[i-1];
         if (i % nk == 0) begin
            t = {t[23:0], t[31:24]};
            t = {sbox_lut[t[31:24]], sbox_lut[t[23:16]], sbox_lut[t[15:8]],
                 sbox_lut[t[7:0]]} ^ {rc, 24'h0};
            rc = rc[7] ? ({rc[6:0], 1'b0} ^ 8'h1b) : {rc[6:0], 1'b0};
         end
         sched[i] = sched[i-nk] ^ t;
      end
   endfunction

   function automatic logic [127:0] encrypt_block(input block_type p);
      logic [7:0] s [0:15];
      logic [7:0] t [0:15];
      logic [7:0] a0, a1, a2, a3;
      logic [127:0] pin;
      logic [127:0] out;
      int nr;
      nr = mode_192 ? 12 : 10;
      pin = {p.high, p.low};
      for (int i = 0; i < 16; i++) s[i] = pin[127-8*i -: 8];
      for (int k = 0; k <= nr; k++) begin
         if (k > 0) begin
            for (int r = 0; r < 4; r++)
               for (int c = 0; c < 4; c++) t[r+4*c] = sbox_lut[s[r+4*((c+r)%4)]];
            for (int i = 0; i < 16; i++) s[i] = t[i];
            if (k < nr) begin
               for (int c = 0; c < 4; c++) begin
                  a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                  s[4*c]   = gmul(a0, 8'h02) ^ gmul(a1, 8'h03) ^ a2 ^ a3;
                  s[4*c+1] = a0 ^ gmul(a1, 8'h02) ^ gmul(a2, 8'h03) ^ a3;
                  s[4*c+2] = a0 ^ a1 ^ gmul(a2, 8'h02) ^ gmul(a3, 8'h03);
                  s[4*c+3] = gmul(a0, 8'h03) ^ a1 ^ a2 ^ gmul(a3, 8'h02);
               end
            end
         end
         for (int i = 0; i < 16; i++) s[i] = s[i] ^ sched[4*k + i/4][31-8*(i%4) -: 8];
      end
      for (int i = 0; i < 16; i++) out[127-8*i -: 8] = s[i];
      return out;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // plaintext driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.plain_high <= '0;
         req_chan.plain_low <= '0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_chan.valid <= 1'b0;
         end else if (plain_queue.size() > 0) begin
            req_chan.valid <= 1'b1;
            req_chan.plain_high <= plain_queue[0].high;
            req_chan.plain_low <= plain_queue[0].low;
            void'(plain_queue.pop_front());
            req_gap <= pick_gap();
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // predict on every accepted plaintext transfer
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         cipher_queue.push_back(encrypt_block({req_chan.plain_high, req_chan.plain_low}));
   end

   // ciphertext receiver with random stalls and an optional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_chan.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) rsp_gap <= pick_gap();
      end
   end

   // ciphertext monitor
   always @(posedge clock) begin
      block_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (cipher_queue.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("unexpected transfer %h %h",
               rsp_chan.cipher_high, rsp_chan.cipher_low);
         end else begin
            want = cipher_queue.pop_front();
            if (want.high !== rsp_chan.cipher_high || want.low !== rsp_chan.cipher_low) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("mismatch: expected %h %h, got %h %h", want.high, want.low,
                     rsp_chan.cipher_high, rsp_chan.cipher_low);
            end
         end
      end
   end

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
            || csr_psel)
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_aes_block_encrypt_top: done, errors");
            $finish;
         end
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [63:0] value);
      @(posedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000}; csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (idx)
         aesbe_pkg::REG_MODE:     mode_192 = value[0];
         aesbe_pkg::REG_KEY_HIGH: key_high = value;
         aesbe_pkg::REG_KEY_MID:  key_mid = value;
         aesbe_pkg::REG_KEY_LOW:  key_low = value;
         default:                 key_low = key_low;
      endcase
      expand_schedule();
   endtask

   task automatic drain();
      while (plain_queue.size() > 0 || req_chan.valid || cipher_queue.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic push_plain(input logic [63:0] h, input logic [63:0] l);
      plain_queue.push_back({h, l});
   endtask

   task automatic random_phase(input int count);
      for (int i = 0; i < count; i++)
         push_plain({$urandom, $urandom}, {$urandom, $urandom});
   endtask

   initial begin
      mode_192 = 1'b0; key_high = '0; key_mid = '0; key_low = '0;
      #1 expand_schedule();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: all-zero key after reset, field extremes
      push_plain('0, '0);
      push_plain('1, '1);
      push_plain(64'h8000000000000000, 64'h0000000000000001);
      push_plain(64'h0123456789abcdef, 64'hfedcba9876543210);
      drain();
      // FIPS-197 appendix vectors, 128-bit
      csr_write(aesbe_pkg::REG_KEY_HIGH, 64'h0001020304050607);
      csr_write(aesbe_pkg::REG_KEY_MID, 64'h08090a0b0c0d0e0f);
      push_plain(64'h0011223344556677, 64'h8899aabbccddeeff);
      push_plain('1, '0);
      drain();
      // low word written while mode stays 128-bit, then 192-bit
      csr_write(aesbe_pkg::REG_KEY_LOW, 64'h1011121314151617);
      csr_write(aesbe_pkg::REG_MODE, 64'hfffffffffffffffe);
      push_plain(64'h0011223344556677, 64'h8899aabbccddeeff);
      drain();
      csr_write(aesbe_pkg::REG_MODE, 64'h1);
      push_plain(64'h0011223344556677, 64'h8899aabbccddeeff);
      push_plain('0, '1);
      drain();
      csr_write(aesbe_pkg::REG_KEY_HIGH, '1);
      csr_write(aesbe_pkg::REG_KEY_MID, '1);
      csr_write(aesbe_pkg::REG_KEY_LOW, '1);
      push_plain('1, '1);
      push_plain('0, '0);
      drain();

      // random phases across several key settings
      for (int ph = 0; ph < 6; ph++) begin
         csr_write(aesbe_pkg::REG_MODE, 64'($urandom_range(0, 1)));
         csr_write(aesbe_pkg::REG_KEY_HIGH, {$urandom, $urandom});
         csr_write(aesbe_pkg::REG_KEY_MID, {$urandom, $urandom});
         csr_write(aesbe_pkg::REG_KEY_LOW, {$urandom, $urandom});
         if (ph == 2) rsp_hold = 300;
         random_phase(140);
         drain();
      end
      repeat (40) @(posedge clock);
      if (mismatches == 0 && cipher_queue.size() == 0)
         $display("tb_aes_block_encrypt_top: done, clean");
      else
         $display("tb_aes_block_encrypt_top: done, errors");
      $finish;
   end

endmodule
`default_nettype wire

// ===== sim.f =====
hw/rtl/aesbe_pkg.sv
hw/rtl/aesbe_req_if.sv
hw/rtl/aesbe_rsp_if.sv
hw/rtl/aesbe_key_expand.sv
hw/rtl/aesbe_round.sv
hw/rtl/aes_block_encrypt_top.sv
verif/tb_aes_block_encrypt_top.sv
